[sv/ttm_pkg.sv]
package ttm_pkg;

	// Width of the serial datapath and of the interval sum.
	localparam int SUM_W = 32;
	// Width of the tempo divisor and quotient.
	localparam int DIV_W = 16;
	// Numerator of the tempo division: milliseconds per minute.
	localparam logic [DIV_W-1:0] TEMPO_NUM = 16'd60000;

	localparam logic [1:0] BEEP_NONE  = 2'd0;
	localparam logic [1:0] BEEP_TAP   = 2'd1;
	localparam logic [1:0] BEEP_BEAT  = 2'd2;
	localparam logic [1:0] BEEP_RESET = 2'd3;

	typedef struct packed {
		logic start;
		logic add;
	} ser_ctl_t;

	typedef struct packed {
		logic done;
		logic ge;
	} ser_sts_t;

	typedef struct packed {
		logic start;
		logic tempo;
	} div_ctl_t;

endpackage

[sv/ttm_serial.sv]
module ttm_serial #(
	parameter int TW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ttm_pkg::ser_ctl_t          ctl,
	input  logic [ttm_pkg::SUM_W-1:0]  a,
	input  logic [ttm_pkg::SUM_W-1:0]  b,
	input  logic [ttm_pkg::SUM_W-1:0]  c,
	output ttm_pkg::ser_sts_t          sts,
	output logic [ttm_pkg::SUM_W-1:0]  result
);
	import ttm_pkg::*;

	localparam int CW = $clog2(SUM_W);
	localparam logic [SUM_W-1:0] TMASK = SUM_W'((64'd1 << TW) - 64'd1);

	logic [SUM_W-1:0] a_q, b_q, c_q, m_q, r_q;
	logic             bw_q, cy_q, add_q;
	logic             busy_q, done_q;
	logic [CW-1:0]    cnt_q;

	logic d_raw, d, bw_n, s, cy_add, cy_sub;

	// First stage: a - b, masked to the time width. Second stage: add or compare c.
	always_comb begin
		d_raw  = a_q[0] ^ b_q[0] ^ bw_q;
		bw_n   = (~a_q[0] & b_q[0]) | (~(a_q[0] ^ b_q[0]) & bw_q);
		d      = d_raw & m_q[0];
		s      = d ^ c_q[0] ^ cy_q;
		cy_add = (d & c_q[0]) | (cy_q & (d ^ c_q[0]));
		cy_sub = (~d & c_q[0]) | (~(d ^ c_q[0]) & cy_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= a;
			b_q   <= b;
			c_q   <= c;
			m_q   <= TMASK;
			bw_q  <= 1'b0;
			cy_q  <= 1'b0;
			add_q <= ctl.add;
		end else if (busy_q) begin
			a_q  <= a_q >> 1;
			b_q  <= b_q >> 1;
			c_q  <= c_q >> 1;
			m_q  <= m_q >> 1;
			r_q  <= {s, r_q[SUM_W-1:1]};
			bw_q <= bw_n;
			cy_q <= add_q ? cy_add : cy_sub;
		end
	end

	assign sts.done = done_q;
	assign sts.ge   = ~cy_q;
	assign result   = r_q;

endmodule

[sv/ttm_div.sv]
module ttm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ttm_pkg::div_ctl_t          ctl,
	input  logic [ttm_pkg::SUM_W-1:0]  dividend,
	input  logic [ttm_pkg::DIV_W-1:0]  divisor,
	output logic                       done,
	output logic [ttm_pkg::SUM_W-1:0]  quotient
);
	import ttm_pkg::*;

	localparam int CW = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] n_q, q_q;
	logic [DIV_W-1:0] d_q, rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;

	logic [DIV_W:0]   trial, diff;
	logic             take;

	// One quotient bit per cycle, dividend shifted out MSB first.
	always_comb begin
		trial = {rem_q, n_q[SUM_W-1]};
		diff  = trial - {1'b0, d_q};
		take  = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.tempo ? CW'(DIV_W) : CW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			n_q   <= ctl.tempo ? {TEMPO_NUM, {(SUM_W - DIV_W){1'b0}}} : dividend;
			d_q   <= divisor;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			q_q   <= {q_q[SUM_W-2:0], take};
			rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

[sv/tap_tempo_metronome.sv]
// Tap tempo metronome. Feed one request per millisecond on s_*, carrying the
// button level; every request yields exactly one result on m_*. Taps are
// stamped at press time; four taps (TAPS) give an average interval and a
// tempo of 60000 / average in bpm, after which a beat click follows each
// time one average interval has passed, the beat index wrapping at
// beats_per_bar. A press held for long_press_ms ticks stops everything and
// gives a reset tone. All time arithmetic runs bit-serially, LSB first,
// through one shared serial subtract/add/compare unit, and both divisions go
// through one shared restoring divider that makes one quotient bit per cycle
// (32 quotient bits for the average, 16 for the tempo). A plain tick makes
// one serial pass against the beat interval while the metronome runs and
// none when it is stopped; a press that is still being timed against the
// threshold adds one serial pass; the release that completes a tempo costs
// the most. The input is ready again as soon as the result appears on m_*.
// The next request is taken while a finished result still waits on m_*.
// Configuration writes are accepted at any time (cfg_ready is tied high)
// but should only be made while no request is in flight.
module tap_tempo_metronome #(
	parameter int TIME_WIDTH = 32,
	parameter int TAPS       = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: [0] button_down, [7:1] zero
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// m_tdata: [1:0] beep_kind, [17:2] bpm, [21:18] beat_index,
	//          [22] beat_valid, [23] running, [24] status_changed, [31:25] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ttm_pkg::*;

	localparam int TCW = $clog2(TAPS + 1);

	localparam logic [0:0] REG_LONG_PRESS = 1'd0;
	localparam logic [0:0] REG_BEATS      = 1'd1;

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PRESS  = 3'd1;
	localparam logic [2:0] ST_TAP    = 3'd2;
	localparam logic [2:0] ST_AVG    = 3'd3;
	localparam logic [2:0] ST_TEMPO  = 3'd4;
	localparam logic [2:0] ST_BEATGO = 3'd5;
	localparam logic [2:0] ST_BEAT   = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	// Next beat position: (pos + 1) mod clamped bar length, one bit per step.
	function automatic logic [3:0] beat_next(input logic [3:0] pos, input logic [4:0] bpb_raw);
		logic [4:0] bpb;
		logic [4:0] num;
		logic [4:0] rem;
		bpb = bpb_raw;
		if (bpb_raw == 5'd0)
			bpb = 5'd1;
		else if (bpb_raw > 5'd16)
			bpb = 5'd16;
		num = {1'b0, pos} + 5'd1;
		rem = '0;
		for (int i = 4; i >= 0; i--) begin
			rem = {rem[3:0], num[i]};
			if (rem >= bpb)
				rem = rem - bpb;
		end
		return rem[3:0];
	endfunction

	logic [2:0]            state_q;

	// Configuration
	logic [15:0]           lp_q;
	logic [4:0]            bpb_q;

	// Metronome state
	logic [TIME_WIDTH-1:0] tick_q;
	logic                  press_q;
	logic [TIME_WIDTH-1:0] press_start_q;
	logic                  long_done_q;
	logic [TCW-1:0]        tap_q;
	logic [TIME_WIDTH-1:0] last_tap_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W-1:0]      avg_q;
	logic [DIV_W-1:0]      tempo_q;
	logic [3:0]            pos_q;
	logic                  shown_q;
	logic [TIME_WIDTH-1:0] last_beat_q;
	logic                  run_q;

	// Per-request scratch
	logic [1:0]            beep_q;
	logic                  chg_q;

	// Output register
	logic                  m_tvalid_q;
	logic [31:0]           m_tdata_q;

	// Serial unit and divider hookup
	ser_ctl_t              ser_ctl;
	ser_sts_t              ser_sts;
	logic [SUM_W-1:0]      ser_a, ser_b, ser_c, ser_result;
	div_ctl_t              div_ctl;
	logic                  div_done;
	logic [SUM_W-1:0]      div_q;
	logic [SUM_W-1:0]      div_dividend;

	logic                  accept;
	logic                  down;
	logic                  long_done_eff;
	logic                  avg_nz;
	logic                  tempo_ok;
	logic                  out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign down      = s_tdata[0];
	assign cfg_ready = 1'b1;

	// A fresh press has not reached the long-press mark yet.
	assign long_done_eff = press_q & long_done_q;
	assign avg_nz        = |avg_q;
	// Tempo is only nonzero for an average that fits the 16-bit divisor.
	assign tempo_ok      = (|div_q) && (div_q[SUM_W-1:DIV_W] == '0);
	assign out_free      = ~m_tvalid_q | m_tready;
	assign div_dividend  = (state_q == ST_TAP) ? ser_result : sum_q;

	// Launch serial passes and divisions.
	always_comb begin
		ser_ctl = '0;
		div_ctl = '0;
		ser_a   = '0;
		ser_b   = '0;
		ser_c   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (down) begin
						if (!long_done_eff) begin
							// press age against the long-press threshold
							ser_ctl.start = 1'b1;
							ser_a = SUM_W'(tick_q);
							ser_b = press_q ? SUM_W'(press_start_q) : SUM_W'(tick_q);
							ser_c = SUM_W'(lp_q);
						end
					end else if (press_q && !long_done_q && tap_q != '0) begin
						if (tap_q < TCW'(TAPS)) begin
							// accumulate the interval since the previous tap
							ser_ctl.start = 1'b1;
							ser_ctl.add   = 1'b1;
							ser_a = SUM_W'(press_start_q);
							ser_b = SUM_W'(last_tap_q);
							ser_c = sum_q;
						end else begin
							div_ctl.start = 1'b1;
						end
					end
				end
			end
			ST_TAP: begin
				if (ser_sts.done && tap_q >= TCW'(TAPS - 1))
					div_ctl.start = 1'b1;
			end
			ST_AVG: begin
				if (div_done && tempo_ok) begin
					div_ctl.start = 1'b1;
					div_ctl.tempo = 1'b1;
				end
			end
			ST_BEATGO: begin
				if (run_q && avg_nz) begin
					// time since the last beat against the average interval
					ser_ctl.start = 1'b1;
					ser_a = SUM_W'(tick_q);
					ser_b = SUM_W'(last_beat_q);
					ser_c = avg_q;
				end
			end
			ST_PRESS, ST_TEMPO, ST_BEAT, ST_DONE: begin
			end
		endcase
	end

	ttm_serial #(
		.TW(TIME_WIDTH)
	) u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ser_ctl),
		.a      (ser_a),
		.b      (ser_b),
		.c      (ser_c),
		.sts    (ser_sts),
		.result (ser_result)
	);

	ttm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_ctl.tempo ? div_q[DIV_W-1:0] : DIV_W'(TAPS - 1)),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			lp_q          <= 16'd1000;
			bpb_q         <= 5'd4;
			tick_q        <= '0;
			press_q       <= 1'b0;
			press_start_q <= '0;
			long_done_q   <= 1'b0;
			tap_q         <= '0;
			last_tap_q    <= '0;
			sum_q         <= '0;
			avg_q         <= '0;
			tempo_q       <= '0;
			pos_q         <= '0;
			shown_q       <= 1'b0;
			last_beat_q   <= '0;
			run_q         <= 1'b0;
			beep_q        <= BEEP_NONE;
			chg_q         <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_LONG_PRESS: lp_q  <= cfg_data;
					REG_BEATS:      bpb_q <= cfg_data[4:0];
				endcase
			end

			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						beep_q <= BEEP_NONE;
						chg_q  <= 1'b0;
						state_q <= ST_BEATGO;
						if (down) begin
							if (!press_q) begin
								press_q       <= 1'b1;
								press_start_q <= tick_q;
								long_done_q   <= 1'b0;
							end
							if (!long_done_eff)
								state_q <= ST_PRESS;
						end else if (press_q) begin
							press_q     <= 1'b0;
							long_done_q <= 1'b0;
							if (!long_done_q) begin
								if (tap_q == '0) begin
									// first tap: stop, keep shown tempo and beat
									run_q      <= 1'b0;
									last_tap_q <= press_start_q;
									tap_q      <= TCW'(1);
									beep_q     <= BEEP_TAP;
								end else if (tap_q < TCW'(TAPS)) begin
									state_q <= ST_TAP;
								end else begin
									state_q <= ST_AVG;
								end
							end
						end
					end
				end
				ST_PRESS: begin
					if (ser_sts.done) begin
						if (ser_sts.ge) begin
							// long press: clear tap and tempo state
							run_q       <= 1'b0;
							tap_q       <= '0;
							sum_q       <= '0;
							avg_q       <= '0;
							last_tap_q  <= '0;
							pos_q       <= '0;
							shown_q     <= 1'b0;
							tempo_q     <= '0;
							long_done_q <= 1'b1;
							beep_q      <= BEEP_RESET;
							chg_q       <= 1'b1;
						end
						state_q <= ST_BEATGO;
					end
				end
				ST_TAP: begin
					if (ser_sts.done) begin
						sum_q      <= ser_result;
						last_tap_q <= press_start_q;
						tap_q      <= tap_q + 1'b1;
						beep_q     <= BEEP_TAP;
						state_q    <= (tap_q >= TCW'(TAPS - 1)) ? ST_AVG : ST_BEATGO;
					end
				end
				ST_AVG: begin
					if (div_done) begin
						avg_q <= div_q;
						if (tempo_ok) begin
							state_q <= ST_TEMPO;
						end else begin
							tempo_q     <= '0;
							pos_q       <= '0;
							shown_q     <= 1'b1;
							last_beat_q <= tick_q;
							run_q       <= 1'b1;
							chg_q       <= 1'b1;
							tap_q       <= '0;
							sum_q       <= '0;
							last_tap_q  <= '0;
							state_q     <= ST_BEATGO;
						end
					end
				end
				ST_TEMPO: begin
					if (div_done) begin
						tempo_q     <= div_q[DIV_W-1:0];
						pos_q       <= '0;
						shown_q     <= 1'b1;
						last_beat_q <= tick_q;
						run_q       <= 1'b1;
						chg_q       <= 1'b1;
						tap_q       <= '0;
						sum_q       <= '0;
						last_tap_q  <= '0;
						state_q     <= ST_BEATGO;
					end
				end
				ST_BEATGO: begin
					state_q <= (run_q && avg_nz) ? ST_BEAT : ST_DONE;
				end
				ST_BEAT: begin
					if (ser_sts.done) begin
						if (ser_sts.ge) begin
							last_beat_q <= tick_q;
							pos_q       <= beat_next(pos_q, bpb_q);
							shown_q     <= 1'b1;
							chg_q       <= 1'b1;
							if (beep_q != BEEP_RESET)
								beep_q <= BEEP_BEAT;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register can take the result
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						tick_q     <= tick_q + 1'b1;
						state_q    <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {7'd0, chg_q, run_q & avg_nz, shown_q,
				shown_q ? pos_q : 4'd0, tempo_q, beep_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[tb/tap_tempo_metronome_tb.sv]
`timescale 1ns / 1ps

module tap_tempo_metronome_tb;
	import ttm_pkg::*;

	// register indexes on the config channel
	localparam logic [0:0] REG_LONG_PRESS    = 1'd0;
	localparam logic [0:0] REG_BEATS_PER_BAR = 1'd1;

	localparam int TAP_COUNT     = 4;
	localparam int PHASES        = 10;
	localparam int PHASE_TICKS   = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 200;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_LIMIT  = 10;

	// Result word as it sits in m_tdata[24:0], lowest field last.
	typedef struct packed {
		logic        changed;
		logic        run;
		logic        beat_on;
		logic [3:0]  beat;
		logic [15:0] bpm;
		logic [1:0]  beep;
	} status_t;

	// Mirror of the metronome state; one expected status word per tick.
	class tempo_ledger;
		status_t     due_status[$];
		int unsigned faults, ticks, checked, tap_clicks, beat_clicks, reset_tones, tempos_set;

		logic [15:0] long_ms;
		logic [4:0]  bar_len;
		logic [31:0] clock_now, press_t, last_tap, sum, avg, last_beat;
		logic [15:0] tempo;
		logic [3:0]  pos;
		bit          pressed, held_out, shown, running;
		int unsigned taps;

		function new();
			long_ms = 16'd1000;
			bar_len = 5'd4;
			clock_now = '0; press_t = '0; last_tap = '0; sum = '0; avg = '0; last_beat = '0;
			tempo = '0; pos = '0; taps = 0;
			pressed = 0; held_out = 0; shown = 0; running = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [15:0] val);
			if (idx == REG_LONG_PRESS) begin
				long_ms = val;
			end else begin
				bar_len = val[4:0];
			end
		endfunction

		function void note_tick(bit down);
			logic [31:0] now;
			int unsigned bpb;
			status_t     want;
			now = clock_now;
			want = '0;
			want.beep = BEEP_NONE;
			if (down) begin
				if (!pressed) begin
					pressed = 1;
					press_t = now;
					held_out = 0;
				end
				// long hold: stop and clear everything
				if (!held_out && (now - press_t) >= 32'(long_ms)) begin
					running = 0; taps = 0; sum = '0; avg = '0; last_tap = '0;
					pos = '0; shown = 0; tempo = '0; held_out = 1;
					want.beep = BEEP_RESET;
					want.changed = 1;
				end
			end else if (pressed) begin
				if (!held_out) begin
					if (taps == 0) begin
						running = 0;
						last_tap = press_t;
						taps = 1;
						want.beep = BEEP_TAP;
					end else if (taps < TAP_COUNT) begin
						sum = sum + (press_t - last_tap);
						last_tap = press_t;
						taps++;
						want.beep = BEEP_TAP;
					end
					if (taps >= TAP_COUNT) begin
						avg = sum / 32'(TAP_COUNT - 1);
						tempo = (avg != 0) ? 16'(32'(TEMPO_NUM) / avg) : '0;
						pos = '0; shown = 1; last_beat = now; running = 1;
						want.changed = 1;
						taps = 0; sum = '0; last_tap = '0;
						tempos_set++;
					end
				end
				pressed = 0;
				held_out = 0;
			end
			if (running && avg != 0 && (now - last_beat) >= avg) begin
				bpb = bar_len;
				if (bpb == 0) bpb = 1;
				if (bpb > 16) bpb = 16;
				last_beat = now;
				pos = 4'((32'(pos) + 1) % bpb);
				shown = 1;
				if (want.beep != BEEP_RESET) want.beep = BEEP_BEAT;
				want.changed = 1;
			end
			clock_now = clock_now + 1;
			want.bpm = tempo;
			want.beat = shown ? pos : 4'd0;
			want.beat_on = shown;
			want.run = running && avg != 0;
			case (want.beep)
				BEEP_TAP:   tap_clicks++;
				BEEP_BEAT:  beat_clicks++;
				BEEP_RESET: reset_tones++;
				default: ;
			endcase
			ticks++;
			due_status.push_back(want);
		endfunction

		function void check_status(logic [31:0] word);
			status_t got, want;
			got = status_t'(word[24:0]);
			if (due_status.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("%0t: status word %h with no tick pending", $realtime, word);
				return;
			end
			want = due_status.pop_front();
			checked++;
			if (got.beep !== want.beep || got.bpm !== want.bpm || got.beat !== want.beat ||
			    got.beat_on !== want.beat_on || got.run !== want.run ||
			    got.changed !== want.changed) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("%0t: result %0d mismatch: beep %0d/%0d bpm %0d/%0d beat %0d/%0d %s%0d/%0d %s%0d/%0d %s%0d/%0d (exp/got)",
						$realtime, checked, want.beep, got.beep, want.bpm, got.bpm,
						want.beat, got.beat, "shown ", want.beat_on, got.beat_on,
						"run ", want.run, got.run, "chg ", want.changed, got.changed);
			end
		endfunction

		function int unsigned pending();
			return due_status.size();
		endfunction

		function void close_out();
			if (due_status.size() != 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("%0d ticks never produced a result", due_status.size());
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	tempo_ledger ledger = new();
	bit          tick_plan[$];
	bit          calm;          // no idling on either side
	bit          hold_request;  // ask the sink for one long stall

	tap_tempo_metronome u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, ledger.pending());
		$display("tap_tempo_metronome regression: fail");
		$finish;
	end

	// Result sink: check every accepted word, stall in random bursts.
	initial begin : result_sink
		int stall_left;
		int quiet_left;
		stall_left = 0;
		quiet_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) ledger.check_status(m_tdata);
			if (hold_request) begin
				hold_request = 0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && quiet_left == 0 && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			// occasionally run a stretch with no stalls at all
			if (quiet_left > 0) quiet_left--;
			else if ($urandom_range(0, 299) == 0) quiet_left = $urandom_range(50, 300);
		end
	end

	// Push the planned button levels, one request per tick.
	task automatic send_plan();
		bit b;
		int gap;
		while (tick_plan.size() != 0) begin
			b = tick_plan.pop_front();
			if (!calm && $urandom_range(0, 7) == 0) begin
				s_tvalid <= 1'b0;
				gap = $urandom_range(1, 19);
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= {7'd0, b};
			do @(posedge clk); while (!s_tready);
			ledger.note_tick(b);
		end
		s_tvalid <= 1'b0;
	endtask

	// Hold until every expected result has come back.
	task automatic wait_idle();
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	// Write both registers back to back; valid stays high across the pair.
	task automatic write_regs(input logic [15:0] long_ms, input logic [15:0] bar);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LONG_PRESS;
		cfg_data  <= long_ms;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_reg(REG_LONG_PRESS, long_ms);
		cfg_index <= REG_BEATS_PER_BAR;
		cfg_data  <= bar;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_reg(REG_BEATS_PER_BAR, bar);
		cfg_valid <= 1'b0;
	endtask

	function automatic void plan_level(int n, bit level);
		repeat (n) tick_plan.push_back(level);
	endfunction

	// n taps, each shorter than the long press threshold unless that threshold is zero
	function automatic void plan_taps(int n, int unsigned long_ms);
		int unsigned cap;
		cap = (long_ms > 1) ? ((long_ms - 1 < 6) ? long_ms - 1 : 6) : 1;
		repeat (n) begin
			plan_level($urandom_range(1, cap), 1'b1);
			plan_level(($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : $urandom_range(1, 3),
				1'b0);
		end
	endfunction

	// Mostly full four-tap sequences with beats after them; the rest is
	// long holds, stray taps, noise and silence.
	function automatic void plan_phase(int unsigned long_ms, int n);
		while (tick_plan.size() < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					plan_taps(TAP_COUNT, long_ms);
					plan_level($urandom_range(5, 60), 1'b0);
				end
				6: begin
					if (long_ms <= 40) begin
						plan_level(long_ms + $urandom_range(1, 4), 1'b1);
						plan_level($urandom_range(1, 6), 1'b0);
					end else begin
						plan_taps(1, long_ms);
					end
				end
				7: repeat (8) tick_plan.push_back(1'($urandom_range(0, 1)));
				8: plan_taps($urandom_range(1, 3), long_ms);
				default: plan_level($urandom_range(1, 30), 1'b0);
			endcase
		end
	endfunction

	initial begin : stimulus
		int unsigned lp_set[PHASES];
		int unsigned bar_set[PHASES];
		int          p;
		lp_set  = '{0, 65535, 3, 7, 1, 12, 2, 0, 0, 4};
		bar_set = '{31, 17, 16, 5, 2, 1, 3, 0, 0, 4};
		lp_set[7]  = $urandom_range(2, 30);
		bar_set[7] = $urandom_range(1, 16);
		lp_set[8]  = $urandom_range(2, 30);
		bar_set[8] = $urandom_range(1, 16);
		calm = 0;
		hold_request = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: four quick taps give an average of two ticks,
		// beats follow, then a lone tap stops the metronome with bpm kept.
		repeat (TAP_COUNT) begin
			tick_plan.push_back(1'b1);
			tick_plan.push_back(1'b0);
		end
		plan_level(5, 1'b0);
		tick_plan.push_back(1'b1);
		tick_plan.push_back(1'b0);
		send_plan();
		wait_idle();

		// Zero beats per bar acts as one; a two-tick hold at threshold one
		// gives the reset tone, possibly on a beat tick.
		write_regs(16'd1, 16'd0);
		repeat (TAP_COUNT) begin
			tick_plan.push_back(1'b1);
			tick_plan.push_back(1'b0);
		end
		plan_level(3, 1'b0);
		plan_level(2, 1'b1);
		send_plan();
		wait_idle();

		for (p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) calm = 1;
			write_regs(16'(lp_set[p]), 16'(bar_set[p]));
			// long sink stall while requests keep coming
			if (p == 2) hold_request = 1;
			plan_phase(lp_set[p], PHASE_TICKS);
			send_plan();
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		ledger.close_out();

		$display("%0d ticks over %0d register settings: %0d tap clicks, %0d beat clicks,",
			ledger.ticks, PHASES + 2, ledger.tap_clicks, ledger.beat_clicks);
		$display("%0d reset tones, %0d tempos computed, %0d results checked, %0d failures",
			ledger.reset_tones, ledger.tempos_set, ledger.checked, ledger.faults);
		if (ledger.faults == 0) begin
			$display("tap_tempo_metronome regression: pass");
		end else begin
			$display("tap_tempo_metronome regression: fail");
		end
		$finish;
	end

endmodule
